// ===== rtl/cqdm_pkg.sv =====
package cqdm_pkg;

  localparam int unsigned MaxPoints  = 1048576;
  localparam int unsigned CountW     = 21;
  localparam int unsigned SampleW    = 24;
  localparam int unsigned VsumW      = 44;
  localparam int unsigned SsumW      = 67;
  localparam int unsigned UnitW      = 99;
  localparam int unsigned MulSteps   = 32;
  localparam int unsigned DivSteps   = 80;
  localparam int unsigned OutDataW   = 328;

  localparam logic [7:0] RegCellVolume = 8'd0;
  localparam logic [7:0] RegDriftLimit = 8'd1;
  localparam logic [7:0] RegGrowthLim  = 8'd2;
  localparam logic [7:0] RegGrowthRun  = 8'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RUN,
    S_CAP,
    S_FIN
  } state_e;

  typedef enum logic [3:0] {
    OP_MASS,
    OP_ENERGY,
    OP_BASE,
    OP_DIFF,
    OP_M1,
    OP_M2,
    OP_E1,
    OP_E2,
    OP_G1,
    OP_G2,
    OP_DM,
    OP_DE,
    OP_DR
  } op_e;

  function automatic logic op_is_div(op_e op);
    return (op == OP_DM) || (op == OP_DE) || (op == OP_DR);
  endfunction

endpackage

// ===== rtl/conserved_quantity_drift_monitor.sv =====
// a sample without tlast is taken while idle, and ready stays high for the next one
// a sample with tlast starts the frame-end sequence (8 multiplies, 3 divides, baseline
// and difference load steps, a finish step) that loads the result register once taken
// throughput: one sample per cycle inside a frame, set by the accumulate adder;
// frame end is bound by the single shared shift-add / restoring-divide unit
// reset: rst_ni low clears sums, baseline, flags and restores register defaults
module conserved_quantity_drift_monitor (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // value[23:0], frame[47:24]
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // mass[63:0], energy[126:64], peak_abs[150:127], mass_rel[182:151],
  // energy_rel[214:183], mass_warn_flag[215], energy_warn_flag[216],
  // blowup_flag[217], mass_warn_at[241:218], energy_warn_at[265:242],
  // blowup_at[289:266], peak_ratio[321:290], zero pad
  output logic [cqdm_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import cqdm_pkg::*;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [31:0] cell_volume_q;
  logic [9:0]  drift_lim_q, growth_lim_q;
  logic [3:0]  growth_run_q;

  logic signed [VsumW-1:0] vsum_q;
  logic [SsumW-1:0]        ssum_q;
  logic [SampleW-1:0]      fpeak_q;
  logic [CountW-1:0]       count_q;
  logic [23:0]             frame_q;

  logic               base_taken_q;
  logic signed [63:0] mass_base_q;
  logic [62:0]        energy_base_q;
  logic [SampleW-1:0] prev_peak_q;
  logic [3:0]         steps_q;
  logic [2:0]         flags_q;
  logic [23:0]        wframe_q [3];
  logic [31:0]        ratio_q;

  logic signed [63:0] mass_q;
  logic [62:0]        energy_q;
  logic [63:0]        mdiff_q, bmag_q;
  logic [62:0]        ediff_q;
  logic               mneg_q, eneg_q;
  logic [UnitW-1:0]   p1_q;
  logic               mover_q, eover_q, gover_q;
  logic [31:0]        mdrift_q, edrift_q, rcand_q;

  logic [UnitW-1:0] a_q, acc_q;
  logic [63:0]      opb_q, rem_q;
  logic [6:0]       cnt_q;

  logic               out_valid_q;
  logic [63:0]        o_mass_q;
  logic [62:0]        o_energy_q;
  logic [23:0]        o_peak_q;
  logic [31:0]        o_mdrift_q, o_edrift_q;

  logic in_fire, fin_go, run_done, div_mode;
  logic signed [SampleW-1:0] sample;
  logic [SampleW-1:0]        smag;
  logic [VsumW-1:0]          vmag;
  logic [UnitW-1:0]          ux, uy;
  logic                      ucin;
  logic [UnitW:0]            usum;
  logic                      take;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign fin_go        = (state_q == S_FIN) && !(out_valid_q && !m_axis_tready);
  assign div_mode      = op_is_div(op_q);
  assign run_done      = div_mode ? (cnt_q == 7'(DivSteps - 1)) : (cnt_q == 7'(MulSteps - 1));

  assign sample = s_axis_tdata[SampleW-1:0];
  assign smag   = sample[SampleW-1] ? SampleW'(-sample) : SampleW'(sample);
  assign vmag   = vsum_q[VsumW-1] ? VsumW'(-vsum_q) : VsumW'(vsum_q);

  // shared adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    if (div_mode) begin
      ux   = {34'b0, rem_q, a_q[DivSteps-1]};
      uy   = ~{35'b0, opb_q};
      ucin = 1'b1;
    end else begin
      ux   = acc_q;
      uy   = opb_q[0] ? a_q : '0;
      ucin = 1'b0;
    end
    usum = {1'b0, ux} + {1'b0, uy} + {{UnitW{1'b0}}, ucin};
    take = usum[UnitW];
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && s_axis_tlast) begin
          state_d = S_LOAD;
          op_d    = OP_MASS;
        end
      end
      S_LOAD: begin
        if (op_q == OP_BASE) begin
          op_d = OP_DIFF;
        end else if (op_q == OP_DIFF) begin
          op_d = OP_M1;
        end else begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (run_done) state_d = S_CAP;
      end
      S_CAP: begin
        if (op_q == OP_DR) begin
          state_d = S_FIN;
        end else begin
          state_d = S_LOAD;
          op_d    = op_e'(op_q + 4'd1);
        end
      end
      S_FIN: begin
        if (fin_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_MASS;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // configuration, accumulation and frame-end bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_volume_q <= 32'd65536;
      drift_lim_q   <= 10'd10;
      growth_lim_q  <= 10'd135;
      growth_run_q  <= 4'd3;
      vsum_q        <= '0;
      ssum_q        <= '0;
      fpeak_q       <= '0;
      count_q       <= '0;
      base_taken_q  <= 1'b0;
      mass_base_q   <= '0;
      energy_base_q <= '0;
      prev_peak_q   <= '0;
      steps_q       <= '0;
      flags_q       <= '0;
      wframe_q[0]   <= '0;
      wframe_q[1]   <= '0;
      wframe_q[2]   <= '0;
      ratio_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegCellVolume: cell_volume_q <= cfg_data_i;
          RegDriftLimit: drift_lim_q   <= cfg_data_i[9:0];
          RegGrowthLim:  growth_lim_q  <= cfg_data_i[9:0];
          RegGrowthRun:  growth_run_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_fire && (count_q < CountW'(MaxPoints))) begin
        count_q <= count_q + CountW'(1);
        vsum_q  <= vsum_q + VsumW'(sample);
        ssum_q  <= ssum_q + SsumW'({24'b0, smag} * {24'b0, smag});
        if (smag > fpeak_q) fpeak_q <= smag;
      end
      if (state_q == S_LOAD && op_q == OP_BASE && !base_taken_q) begin
        base_taken_q  <= 1'b1;
        mass_base_q   <= mass_q;
        energy_base_q <= energy_q;
        prev_peak_q   <= fpeak_q;
      end
      if (fin_go) begin
        logic [2:0]  fl;
        logic [3:0]  st;
        fl = flags_q;
        st = steps_q;
        if (mass_base_q != 0 && !fl[0] && mover_q) begin
          fl[0]       = 1'b1;
          wframe_q[0] <= frame_q;
        end
        if (energy_base_q != 0 && !fl[1] && eover_q) begin
          fl[1]       = 1'b1;
          wframe_q[1] <= frame_q;
        end
        if (prev_peak_q != 0) begin
          if (gover_q) begin
            if (st != 4'd15) st = st + 4'd1;
          end else begin
            st = 4'd0;
          end
          if (!fl[2] && st >= growth_run_q) begin
            fl[2]       = 1'b1;
            wframe_q[2] <= frame_q;
            ratio_q     <= rcand_q;
          end
        end
        flags_q     <= fl;
        steps_q     <= st;
        prev_peak_q <= fpeak_q;
        vsum_q      <= '0;
        ssum_q      <= '0;
        fpeak_q     <= '0;
        count_q     <= '0;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // shared unit and captured frame-end values
  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tlast) frame_q <= s_axis_tdata[47:24];
    unique case (state_q)
      S_LOAD: begin
        cnt_q <= '0;
        acc_q <= '0;
        rem_q <= '0;
        unique case (op_q)
          OP_MASS: begin
            a_q   <= UnitW'(vmag);
            opb_q <= 64'(cell_volume_q);
          end
          OP_ENERGY: begin
            a_q   <= UnitW'(ssum_q);
            opb_q <= 64'(cell_volume_q);
          end
          OP_DIFF: begin
            mneg_q  <= mass_q < mass_base_q;
            mdiff_q <= (mass_q < mass_base_q) ? 64'(mass_base_q - mass_q)
                                              : 64'(mass_q - mass_base_q);
            bmag_q  <= mass_base_q[63] ? 64'(-mass_base_q) : 64'(mass_base_q);
            eneg_q  <= energy_q < energy_base_q;
            ediff_q <= (energy_q < energy_base_q) ? (energy_base_q - energy_q)
                                                  : (energy_q - energy_base_q);
          end
          OP_M1: begin
            a_q   <= UnitW'(mdiff_q);
            opb_q <= 64'd1000;
          end
          OP_M2: begin
            a_q   <= UnitW'(bmag_q);
            opb_q <= 64'(drift_lim_q);
          end
          OP_E1: begin
            a_q   <= UnitW'(ediff_q);
            opb_q <= 64'd1000;
          end
          OP_E2: begin
            a_q   <= UnitW'(energy_base_q);
            opb_q <= 64'(drift_lim_q);
          end
          OP_G1: begin
            a_q   <= UnitW'(fpeak_q);
            opb_q <= 64'd100;
          end
          OP_G2: begin
            a_q   <= UnitW'(prev_peak_q);
            opb_q <= 64'(growth_lim_q);
          end
          OP_DM: begin
            a_q   <= UnitW'({mdiff_q, 16'b0});
            opb_q <= bmag_q;
          end
          OP_DE: begin
            a_q   <= UnitW'({ediff_q, 16'b0});
            opb_q <= 64'(energy_base_q);
          end
          OP_DR: begin
            a_q   <= UnitW'({fpeak_q, 16'b0});
            opb_q <= 64'(prev_peak_q);
          end
          default: ;
        endcase
      end
      S_RUN: begin
        cnt_q <= cnt_q + 7'd1;
        a_q   <= a_q << 1;
        if (div_mode) begin
          rem_q <= take ? usum[63:0] : ux[63:0];
          acc_q <= {acc_q[UnitW-2:0], take};
        end else begin
          opb_q <= opb_q >> 1;
          acc_q <= usum[UnitW-1:0];
        end
      end
      S_CAP: begin
        unique case (op_q)
          OP_MASS: mass_q <= vsum_q[VsumW-1] ? -$signed(acc_q[79:16])
                                              : $signed(acc_q[79:16]);
          OP_ENERGY: energy_q <= (acc_q[98:95] != 0) ? {63{1'b1}} : acc_q[94:32];
          OP_M1, OP_E1, OP_G1: p1_q <= acc_q;
          OP_M2: mover_q <= p1_q > acc_q;
          OP_E2: eover_q <= p1_q > acc_q;
          OP_G2: gover_q <= p1_q > acc_q;
          OP_DM: begin
            if (mass_base_q == 0) mdrift_q <= '0;
            else if (acc_q[79:31] != 0) mdrift_q <= mneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else mdrift_q <= mneg_q ? 32'(-acc_q[31:0]) : acc_q[31:0];
          end
          OP_DE: begin
            if (energy_base_q == 0) edrift_q <= '0;
            else if (acc_q[79:31] != 0) edrift_q <= eneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else edrift_q <= eneg_q ? 32'(-acc_q[31:0]) : acc_q[31:0];
          end
          OP_DR: rcand_q <= (acc_q[79:32] != 0) ? 32'hFFFF_FFFF : acc_q[31:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      o_mass_q   <= mass_q;
      o_energy_q <= energy_q;
      o_peak_q   <= fpeak_q;
      o_mdrift_q <= mdrift_q;
      o_edrift_q <= edrift_q;
    end
  end

  // sticky state only changes together with the result register
  assign m_axis_tdata = {6'b0, ratio_q, wframe_q[2], wframe_q[1], wframe_q[0], flags_q,
                         o_edrift_q, o_mdrift_q, o_peak_q, o_energy_q, o_mass_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxPoints))
    else $error("sample count beyond limit");

  a_flags_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q[0] |=> flags_q[0])
    else $error("mass warning cleared");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> (state_q == S_LOAD && op_q == OP_MASS))
    else $error("frame end sequence not started");

  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> out_valid_q)
    else $error("result not presented");

endmodule
